[sv/cses_pkg.sv]
// ----------------------------------------------------------------------------
// CSR sparse matrix Euler stepper: shared package
// Types, constants and command codes used by the stepper and its units.
// ----------------------------------------------------------------------------
package cses_pkg;

	localparam int MAX_ROWS     = 1024;
	localparam int MAX_NONZEROS = 8192;
	localparam int ROW_W        = $clog2(MAX_ROWS);
	localparam int NROW_W       = $clog2(MAX_ROWS + 1);
	localparam int NZ_AW        = $clog2(MAX_NONZEROS);
	localparam int NZ_CW        = $clog2(MAX_NONZEROS + 1);
	localparam int NZ_DW        = 2 * ROW_W + 64;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_APPEND = 3'd1;
	localparam logic [2:0] CMD_WRITE  = 3'd2;
	localparam logic [2:0] CMD_STEP   = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_REJ  = 2'd3;

	localparam logic CFG_ROW_COUNT = 1'b0;
	localparam logic CFG_TIME_STEP = 1'b1;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [9:0]  index;
		logic [9:0]  column;
		logic [63:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] data;
	} res_word_t;

	typedef enum logic {
		FOP_MUL,
		FOP_ADD
	} fpu_op_t;

	typedef struct packed {
		logic    start;
		fpu_op_t op;
	} fpu_req_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_NORM,
		F_ROUND
	} fpu_state_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RDWAIT,
		S_ROW,
		S_NZRD,
		S_NZ,
		S_SV,
		S_MUL,
		S_ADD,
		S_SCALE,
		S_SMUL,
		S_SADD,
		S_CPRD,
		S_CPWR
	} main_state_t;

endpackage

[sv/cses_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cses_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/cses_fpu.sv]
// ----------------------------------------------------------------------------
// Binary64 multiply and add unit
// Multi-cycle unit: shift-add mantissa product, step-wise normalization and
// round to nearest even.
// ----------------------------------------------------------------------------
module cses_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  cses_pkg::fpu_req_t req,
	input  logic [63:0]        opa,
	input  logic [63:0]        opb,
	output logic               done,
	output logic [63:0]        res
);

	localparam logic [5:0] MulSteps = 6'd53;
	localparam logic [63:0] DefNan = 64'hFFF8_0000_0000_0000;

	function automatic logic [56:0] shr_jam(input logic [56:0] x, input logic [5:0] d);
		logic [56:0] s;
		logic [56:0] lost;
		s    = x >> d;
		lost = x & ~({57{1'b1}} << d);
		return s | {56'b0, |lost};
	endfunction

	cses_pkg::fpu_state_t state_q, state_d;

	logic               sign_q;
	logic signed [13:0] exp_q;
	logic [56:0]        w_q;
	logic [105:0]       mcand_q;
	logic [52:0]        mplier_q;
	logic [105:0]       acc_q;
	logic [5:0]         cnt_q;
	logic [63:0]        res_q;
	logic               done_q;

	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [10:0] ea, eb;
	logic [52:0] ma, mb;
	logic        spec_hit;
	logic [63:0] spec_val;

	logic        a_big, s_big, s_small;
	logic [52:0] m_big, m_small;
	logic [10:0] e_big, e_small, e_diff;
	logic [5:0]  d_al;
	logic [56:0] x_big, x_small, add_w;

	logic signed [13:0] d1;
	logic [5:0]         dn;
	logic               norm_zero, norm_up, norm_den, norm_left;

	logic [52:0]        r_mant, r_mf;
	logic [53:0]        r_m1;
	logic               r_up;
	logic signed [13:0] r_e;
	logic [63:0]        r_val;

	always_comb begin
		sa     = opa[63];
		sb     = opb[63];
		a_nan  = (&opa[62:52]) & (|opa[51:0]);
		b_nan  = (&opb[62:52]) & (|opb[51:0]);
		a_inf  = (&opa[62:52]) & ~(|opa[51:0]);
		b_inf  = (&opb[62:52]) & ~(|opb[51:0]);
		a_zero = ~(|opa[62:0]);
		b_zero = ~(|opb[62:0]);
		ea     = (opa[62:52] == 11'd0) ? 11'd1 : opa[62:52];
		eb     = (opb[62:52] == 11'd0) ? 11'd1 : opb[62:52];
		ma     = {|opa[62:52], opa[51:0]};
		mb     = {|opb[62:52], opb[51:0]};

		spec_hit = 1'b1;
		spec_val = 64'b0;
		priority if (a_nan) begin
			spec_val = opa | 64'h0008_0000_0000_0000;
		end else if (b_nan) begin
			spec_val = opb | 64'h0008_0000_0000_0000;
		end else if (req.op == cses_pkg::FOP_MUL) begin
			priority if ((a_inf & b_zero) | (a_zero & b_inf)) begin
				spec_val = DefNan;
			end else if (a_inf | b_inf) begin
				spec_val = {sa ^ sb, 11'h7FF, 52'b0};
			end else if (a_zero | b_zero) begin
				spec_val = {sa ^ sb, 63'b0};
			end else begin
				spec_hit = 1'b0;
			end
		end else begin
			priority if (a_inf & b_inf & (sa != sb)) begin
				spec_val = DefNan;
			end else if (a_inf) begin
				spec_val = opa;
			end else if (b_inf) begin
				spec_val = opb;
			end else if (a_zero & b_zero) begin
				spec_val = {sa & sb, 63'b0};
			end else begin
				spec_hit = 1'b0;
			end
		end
	end

	always_comb begin
		a_big   = opa[62:0] >= opb[62:0];
		s_big   = a_big ? sa : sb;
		s_small = a_big ? sb : sa;
		m_big   = a_big ? ma : mb;
		m_small = a_big ? mb : ma;
		e_big   = a_big ? ea : eb;
		e_small = a_big ? eb : ea;
		e_diff  = e_big - e_small;
		d_al    = (e_diff > 11'd63) ? 6'd63 : e_diff[5:0];
		x_big   = {1'b0, m_big, 3'b0};
		x_small = shr_jam({1'b0, m_small, 3'b0}, d_al);
		add_w   = (s_big == s_small) ? (x_big + x_small) : (x_big - x_small);
	end

	always_comb begin
		d1        = 14'sd1 - exp_q;
		dn        = (d1 > 14'sd63) ? 6'd63 : d1[5:0];
		norm_zero = (w_q == 57'b0);
		norm_up   = !norm_zero && w_q[56];
		norm_den  = !norm_zero && !w_q[56] && (exp_q < 14'sd1);
		norm_left = !norm_zero && !w_q[56] && !(exp_q < 14'sd1) && !w_q[55]
			&& (exp_q > 14'sd1);
	end

	always_comb begin
		r_mant = w_q[55:3];
		r_up   = w_q[2] & ((|w_q[1:0]) | r_mant[0]);
		r_m1   = {1'b0, r_mant} + {53'b0, r_up};
		if (r_m1[53]) begin
			r_mf = r_m1[53:1];
			r_e  = exp_q + 14'sd1;
		end else begin
			r_mf = r_m1[52:0];
			r_e  = exp_q;
		end
		priority if (norm_zero) begin
			r_val = 64'b0;
		end else if (r_e > 14'sd2046) begin
			r_val = {sign_q, 11'h7FF, 52'b0};
		end else begin
			r_val = {sign_q, r_mf[52] ? r_e[10:0] : 11'b0, r_mf[51:0]};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cses_pkg::F_IDLE: begin
				if (req.start && !spec_hit) begin
					state_d = (req.op == cses_pkg::FOP_MUL) ? cses_pkg::F_MUL
						: cses_pkg::F_NORM;
				end
			end
			cses_pkg::F_MUL: begin
				if (cnt_q == MulSteps) begin
					state_d = cses_pkg::F_NORM;
				end
			end
			cses_pkg::F_NORM: begin
				if (!norm_up && !norm_den && !norm_left) begin
					state_d = cses_pkg::F_ROUND;
				end
			end
			cses_pkg::F_ROUND: begin
				state_d = cses_pkg::F_IDLE;
			end
			default: begin
				state_d = cses_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cses_pkg::F_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				cses_pkg::F_IDLE: begin
					if (req.start) begin
						if (spec_hit) begin
							res_q  <= spec_val;
							done_q <= 1'b1;
						end else if (req.op == cses_pkg::FOP_MUL) begin
							sign_q   <= sa ^ sb;
							exp_q    <= $signed({3'b0, ea}) + $signed({3'b0, eb}) - 14'sd1022;
							mcand_q  <= {53'b0, ma};
							mplier_q <= mb;
							acc_q    <= 106'b0;
							cnt_q    <= 6'd0;
						end else begin
							sign_q <= s_big;
							exp_q  <= $signed({3'b0, e_big});
							w_q    <= add_w;
						end
					end
				end
				cses_pkg::F_MUL: begin
					if (cnt_q == MulSteps) begin
						w_q <= {1'b0, acc_q[105:51], acc_q[50] | (|acc_q[49:0])};
					end else begin
						if (mplier_q[0]) begin
							acc_q <= acc_q + mcand_q;
						end
						mcand_q  <= {mcand_q[104:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[52:1]};
						cnt_q    <= cnt_q + 6'd1;
					end
				end
				cses_pkg::F_NORM: begin
					priority if (norm_up) begin
						w_q   <= {1'b0, w_q[56:2], w_q[1] | w_q[0]};
						exp_q <= exp_q + 14'sd1;
					end else if (norm_den) begin
						w_q   <= shr_jam(w_q, dn);
						exp_q <= 14'sd1;
					end else if (norm_left) begin
						w_q   <= {w_q[55:0], 1'b0};
						exp_q <= exp_q - 14'sd1;
					end else begin
						w_q <= w_q;
					end
				end
				cses_pkg::F_ROUND: begin
					res_q  <= r_val;
					done_q <= 1'b1;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[sv/csr_spmv_euler_step_top.sv]
// Simple commands give their result word in the cycle after acceptance; an in-range
// read first passes the state RAM read register and S_RDWAIT. A step runs each stored
// nonzero of a row and then the row's scaling through the shared binary64 unit
// (shift-add multiply plus normalization), then copies the active rows back; one word at a time.
// After reset all 1024 state vector entries are cleared with busy high.
// ----------------------------------------------------------------------------
// CSR sparse matrix Euler stepper
// Holds a CSR matrix and a state vector and advances u by u + dt*(B*u).
// ----------------------------------------------------------------------------
module csr_spmv_euler_step_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cses_pkg::in_word_t   request,
	output logic                 result_strobe,
	output cses_pkg::res_word_t  result,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [63:0]          cfg_data
);

	cses_pkg::main_state_t state_q, state_d;

	logic [cses_pkg::NROW_W-1:0] row_count_q;
	logic [63:0]                 time_step_q;
	logic [cses_pkg::NZ_CW-1:0]  total_q;
	logic [cses_pkg::ROW_W-1:0]  last_row_q;
	logic [cses_pkg::ROW_W-1:0]  i_q;
	logic [cses_pkg::NZ_CW-1:0]  j_q;
	logic [cses_pkg::ROW_W-1:0]  c_q;
	logic [63:0]                 sum_q;
	logic                        res_strobe_q;
	cses_pkg::res_word_t         res_q;

	logic [cses_pkg::NROW_W-1:0] n_rows, n_m1;
	logic [cses_pkg::ROW_W-1:0]  last_idx;
	logic accept, in_rng, col_rng, app_ok, take, row_last, copy_last, clr_last;

	logic                        nz_we, nz_re;
	logic [cses_pkg::NZ_AW-1:0]  nz_waddr, nz_raddr;
	logic [cses_pkg::NZ_DW-1:0]  nz_wdata, nz_rdata;
	logic [cses_pkg::ROW_W-1:0]  nz_row, nz_col;
	logic                        sv_we, sv_re, nv_we, nv_re;
	logic [cses_pkg::ROW_W-1:0]  sv_waddr, sv_raddr, nv_waddr, nv_raddr;
	logic [63:0]                 sv_wdata, sv_rdata, nv_wdata, nv_rdata;

	cses_pkg::fpu_req_t fpu_req;
	logic [63:0]        fpu_a, fpu_b, fpu_res;
	logic               fpu_done;

	always_comb begin
		if (row_count_q == '0) begin
			n_rows = cses_pkg::NROW_W'(1);
		end else if (row_count_q > cses_pkg::NROW_W'(cses_pkg::MAX_ROWS)) begin
			n_rows = cses_pkg::NROW_W'(cses_pkg::MAX_ROWS);
		end else begin
			n_rows = row_count_q;
		end
		n_m1      = n_rows - cses_pkg::NROW_W'(1);
		last_idx  = n_m1[cses_pkg::ROW_W-1:0];
		accept    = start && !busy;
		in_rng    = {1'b0, request.index} < n_rows;
		col_rng   = {1'b0, request.column} < n_rows;
		app_ok    = (total_q != cses_pkg::NZ_CW'(cses_pkg::MAX_NONZEROS)) && in_rng
			&& col_rng && (request.index >= last_row_q);
		nz_row    = nz_rdata[cses_pkg::NZ_DW-1 -: cses_pkg::ROW_W];
		nz_col    = nz_rdata[64 +: cses_pkg::ROW_W];
		take      = (j_q < total_q) && (nz_row == i_q);
		row_last  = (i_q == last_idx);
		copy_last = (c_q == last_idx);
		clr_last  = (c_q == cses_pkg::ROW_W'(cses_pkg::MAX_ROWS - 1));
	end

	assign busy = (state_q != cses_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cses_pkg::S_CLEAR:  if (clr_last) state_d = cses_pkg::S_IDLE;
			cses_pkg::S_IDLE: begin
				if (accept && request.cmd == cses_pkg::CMD_STEP) begin
					state_d = cses_pkg::S_ROW;
				end else if (accept && request.cmd == cses_pkg::CMD_READ && in_rng) begin
					state_d = cses_pkg::S_RDWAIT;
				end
			end
			cses_pkg::S_RDWAIT: state_d = cses_pkg::S_IDLE;
			cses_pkg::S_ROW:    state_d = cses_pkg::S_NZRD;
			cses_pkg::S_NZRD:   state_d = cses_pkg::S_NZ;
			cses_pkg::S_NZ:     state_d = take ? cses_pkg::S_SV : cses_pkg::S_SCALE;
			cses_pkg::S_SV:     state_d = cses_pkg::S_MUL;
			cses_pkg::S_MUL:    if (fpu_done) state_d = cses_pkg::S_ADD;
			cses_pkg::S_ADD:    if (fpu_done) state_d = cses_pkg::S_NZRD;
			cses_pkg::S_SCALE:  state_d = cses_pkg::S_SMUL;
			cses_pkg::S_SMUL:   if (fpu_done) state_d = cses_pkg::S_SADD;
			cses_pkg::S_SADD: begin
				if (fpu_done) begin
					state_d = row_last ? cses_pkg::S_CPRD : cses_pkg::S_ROW;
				end
			end
			cses_pkg::S_CPRD:   state_d = cses_pkg::S_CPWR;
			cses_pkg::S_CPWR:   state_d = copy_last ? cses_pkg::S_IDLE : cses_pkg::S_CPRD;
			default:            state_d = cses_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		nz_we    = 1'b0;
		nz_waddr = total_q[cses_pkg::NZ_AW-1:0];
		nz_wdata = {request.index, request.column, request.value};
		nz_re    = 1'b0;
		nz_raddr = j_q[cses_pkg::NZ_AW-1:0];
		sv_we    = 1'b0;
		sv_waddr = c_q;
		sv_wdata = 64'b0;
		sv_re    = 1'b0;
		sv_raddr = request.index;
		nv_we    = 1'b0;
		nv_waddr = i_q;
		nv_wdata = fpu_res;
		nv_re    = 1'b0;
		nv_raddr = c_q;
		fpu_req  = '{start: 1'b0, op: cses_pkg::FOP_MUL};
		fpu_a    = sum_q;
		fpu_b    = fpu_res;
		unique case (state_q)
			cses_pkg::S_CLEAR: begin
				sv_we = 1'b1;
			end
			cses_pkg::S_IDLE: begin
				if (accept) begin
					unique case (request.cmd)
						cses_pkg::CMD_APPEND: nz_we = app_ok;
						cses_pkg::CMD_WRITE: begin
							sv_we    = in_rng;
							sv_waddr = request.index;
							sv_wdata = request.value;
						end
						cses_pkg::CMD_READ:   sv_re = in_rng;
						default:              sv_re = 1'b0;
					endcase
				end
			end
			cses_pkg::S_NZRD: begin
				nz_re = 1'b1;
			end
			cses_pkg::S_NZ: begin
				sv_re    = take;
				sv_raddr = nz_col;
			end
			cses_pkg::S_SV: begin
				fpu_req = '{start: 1'b1, op: cses_pkg::FOP_MUL};
				fpu_a   = nz_rdata[63:0];
				fpu_b   = sv_rdata;
			end
			cses_pkg::S_MUL: begin
				fpu_req = '{start: fpu_done, op: cses_pkg::FOP_ADD};
			end
			cses_pkg::S_SCALE: begin
				sv_re    = 1'b1;
				sv_raddr = i_q;
				fpu_req  = '{start: 1'b1, op: cses_pkg::FOP_MUL};
				fpu_a    = time_step_q;
				fpu_b    = sum_q;
			end
			cses_pkg::S_SMUL: begin
				fpu_req = '{start: fpu_done, op: cses_pkg::FOP_ADD};
				fpu_a   = fpu_res;
				fpu_b   = sv_rdata;
			end
			cses_pkg::S_SADD: begin
				nv_we = fpu_done;
			end
			cses_pkg::S_CPRD: begin
				nv_re = 1'b1;
			end
			cses_pkg::S_CPWR: begin
				sv_we    = 1'b1;
				sv_wdata = nv_rdata;
			end
			default: begin
				nz_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cses_pkg::S_CLEAR;
			row_count_q  <= cses_pkg::NROW_W'(1);
			time_step_q  <= 64'b0;
			total_q      <= '0;
			last_row_q   <= '0;
			i_q          <= '0;
			j_q          <= '0;
			c_q          <= '0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_strobe_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					cses_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data[cses_pkg::NROW_W-1:0];
					cses_pkg::CFG_TIME_STEP: time_step_q <= cfg_data;
					default:                 time_step_q <= time_step_q;
				endcase
			end
			unique case (state_q)
				cses_pkg::S_CLEAR: begin
					c_q <= c_q + cses_pkg::ROW_W'(1);
				end
				cses_pkg::S_IDLE: begin
					if (accept) begin
						res_q.data <= 64'b0;
						unique case (request.cmd)
							cses_pkg::CMD_CLEAR: begin
								total_q      <= '0;
								last_row_q   <= '0;
								res_strobe_q <= 1'b1;
								res_q.kind   <= cses_pkg::KIND_ACK;
							end
							cses_pkg::CMD_APPEND: begin
								res_strobe_q <= 1'b1;
								res_q.kind   <= app_ok ? cses_pkg::KIND_ACK : cses_pkg::KIND_REJ;
								if (app_ok) begin
									total_q    <= total_q + cses_pkg::NZ_CW'(1);
									last_row_q <= request.index;
								end
							end
							cses_pkg::CMD_WRITE: begin
								res_strobe_q <= 1'b1;
								res_q.kind   <= in_rng ? cses_pkg::KIND_ACK : cses_pkg::KIND_REJ;
							end
							cses_pkg::CMD_STEP: begin
								i_q <= '0;
								j_q <= '0;
							end
							cses_pkg::CMD_READ: begin
								res_strobe_q <= !in_rng;
								res_q.kind   <= cses_pkg::KIND_REJ;
							end
							default: begin
								res_strobe_q <= 1'b1;
								res_q.kind   <= cses_pkg::KIND_REJ;
							end
						endcase
					end
				end
				cses_pkg::S_RDWAIT: begin
					res_strobe_q <= 1'b1;
					res_q.kind   <= cses_pkg::KIND_READ;
					res_q.data   <= sv_rdata;
				end
				cses_pkg::S_ROW: begin
					sum_q <= 64'b0;
				end
				cses_pkg::S_ADD: begin
					if (fpu_done) begin
						sum_q <= fpu_res;
						j_q   <= j_q + cses_pkg::NZ_CW'(1);
					end
				end
				cses_pkg::S_SADD: begin
					if (fpu_done) begin
						if (row_last) begin
							c_q <= '0;
						end else begin
							i_q <= i_q + cses_pkg::ROW_W'(1);
						end
					end
				end
				cses_pkg::S_CPWR: begin
					c_q <= c_q + cses_pkg::ROW_W'(1);
					if (copy_last) begin
						res_strobe_q <= 1'b1;
						res_q.kind   <= cses_pkg::KIND_DONE;
						res_q.data   <= 64'b0;
					end
				end
				default: begin
					res_strobe_q <= 1'b0;
				end
			endcase
		end
	end

	assign result_strobe = res_strobe_q;
	assign result        = res_q;

	cses_ram #(.WIDTH(cses_pkg::NZ_DW), .DEPTH(cses_pkg::MAX_NONZEROS)) u_nz_ram (
		.clk   (clk),
		.we    (nz_we),
		.waddr (nz_waddr),
		.wdata (nz_wdata),
		.re    (nz_re),
		.raddr (nz_raddr),
		.rdata (nz_rdata)
	);

	cses_ram #(.WIDTH(64), .DEPTH(cses_pkg::MAX_ROWS)) u_sv_ram (
		.clk   (clk),
		.we    (sv_we),
		.waddr (sv_waddr),
		.wdata (sv_wdata),
		.re    (sv_re),
		.raddr (sv_raddr),
		.rdata (sv_rdata)
	);

	cses_ram #(.WIDTH(64), .DEPTH(cses_pkg::MAX_ROWS)) u_nv_ram (
		.clk   (clk),
		.we    (nv_we),
		.waddr (nv_waddr),
		.wdata (nv_wdata),
		.re    (nv_re),
		.raddr (nv_raddr),
		.rdata (nv_rdata)
	);

	cses_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.opa    (fpu_a),
		.opb    (fpu_b),
		.done   (fpu_done),
		.res    (fpu_res)
	);

endmodule
